FILE: rtl/sxlf_pkg.sv
package sxlf_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int KERNEL_ROWS = 3;
    localparam int GRAD_BITS = PIXEL_BITS + 3;
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = 8'hFF;

    localparam int CFG_WIDTH_BITS = 12;
    localparam int CFG_HEIGHT_BITS = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_WIDTH_BITS-1:0] WIDTH_RESET = 12'd640;
    localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_MIN = 16'd3;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_BITS = 3;
    localparam int FIFO_CNT_BITS = 4;
    localparam int PUSH_MAX = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } sxlf_cfg_idx_t;

    typedef struct packed {
        logic                  command;
        logic [PIXEL_BITS-1:0] pixel_value;
    } sxlf_in_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] gradient_value;
        logic                  row_end;
        logic                  image_end;
    } sxlf_res_t;

    typedef struct packed {
        logic                  valid;
        logic                  flush;
        logic                  last;
        logic                  emit_grad;
        logic                  grad_zero;
        logic                  emit_row_end;
        logic [PIXEL_BITS-1:0] pixel;
    } sxlf_op_t;

    typedef struct packed {
        logic      push0;
        logic      push1;
        sxlf_res_t res0;
        sxlf_res_t res1;
    } sxlf_push_t;

endpackage

FILE: rtl/sxlf_line_store.sv
module sxlf_line_store
    import sxlf_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int ADDR_BITS = 11
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_BITS-1:0]  wr_addr,
    input  logic [PIXEL_BITS-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_BITS-1:0]  rd_addr,
    output logic [PIXEL_BITS-1:0] rd_data
);

    logic [PIXEL_BITS-1:0] mem_reg [DEPTH];
    logic [PIXEL_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sxlf_ctrl.sv
module sxlf_ctrl
    import sxlf_pkg::*;
#(
    parameter int COL_BITS = 11
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  sxlf_in_t                   in_data,
    input  logic [COL_BITS-1:0]        last_col,
    input  logic [CFG_HEIGHT_BITS-1:0] used_height,
    output logic                       rd_en,
    output logic [COL_BITS-1:0]        rd_addr,
    output sxlf_op_t                   op,
    output logic [COL_BITS-1:0]        op_addr
);

    logic [COL_BITS-1:0]        column_count_reg, column_count_next;
    logic [CFG_HEIGHT_BITS-1:0] row_count_reg, row_count_next;
    logic [COL_BITS-1:0]        flush_count_reg, flush_count_next;
    sxlf_op_t                   op_reg, op_next;
    logic [COL_BITS-1:0]        op_addr_reg;
    logic                       pix_go;
    logic                       col_last;
    logic                       fl_last;

    always_comb
    begin
        pix_go = !in_data.command && (flush_count_reg == '0) && (row_count_reg < used_height);
        col_last = column_count_reg >= last_col;
        fl_last = flush_count_reg >= last_col;
        column_count_next = column_count_reg;
        row_count_next = row_count_reg;
        flush_count_next = flush_count_reg;
        op_next = '0;
        op_next.pixel = in_data.pixel_value;
        if (fire && in_data.command)
        begin
            op_next.valid = 1'b1;
            op_next.flush = 1'b1;
            op_next.last = fl_last;
            if (fl_last)
            begin
                flush_count_next = '0;
                row_count_next = '0;
                column_count_next = '0;
            end
            else
            begin
                flush_count_next = flush_count_reg + COL_BITS'(1);
            end
        end
        else if (fire && pix_go)
        begin
            op_next.valid = 1'b1;
            op_next.last = col_last;
            op_next.emit_grad = (row_count_reg != '0) && (column_count_reg != '0);
            op_next.grad_zero = (row_count_reg == CFG_HEIGHT_BITS'(1))
                                || (column_count_reg == COL_BITS'(1));
            op_next.emit_row_end = (row_count_reg != '0) && col_last;
            if (col_last)
            begin
                column_count_next = '0;
                row_count_next = row_count_reg + CFG_HEIGHT_BITS'(1);
            end
            else
            begin
                column_count_next = column_count_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg <= '0;
            flush_count_reg <= '0;
            op_reg <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg <= row_count_next;
            flush_count_reg <= flush_count_next;
            op_reg <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_addr_reg <= column_count_reg;
    end

    assign rd_en = fire && pix_go;
    assign rd_addr = column_count_reg;
    assign op = op_reg;
    assign op_addr = op_addr_reg;

    a_flush_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_data.command && fl_last
        |=> row_count_reg == '0 && column_count_reg == '0 && flush_count_reg == '0)
        else $error("flush end did not restart the image");

    a_flush_no_pixel_result: assert property (@(posedge clk) disable iff (!rst_n)
        op_reg.valid && op_reg.flush |-> !op_reg.emit_grad && !op_reg.emit_row_end)
        else $error("flush request marked with pixel results");

    a_pixel_blocked_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        flush_count_reg != '0 && fire && !in_data.command |=> !op_reg.valid)
        else $error("pixel processed during a flush");

endmodule

FILE: rtl/sxlf_grad.sv
module sxlf_grad
    import sxlf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sxlf_op_t              op,
    input  logic [PIXEL_BITS-1:0] top,
    input  logic [PIXEL_BITS-1:0] mid,
    output sxlf_push_t            push
);

    logic [KERNEL_ROWS-1:0][1:0][PIXEL_BITS-1:0] win_reg, win_next;
    logic signed [GRAD_BITS-1:0] acc;
    logic [PIXEL_BITS-1:0]       grad;
    sxlf_res_t                   grad_res;
    sxlf_res_t                   end_res;

    always_comb
    begin
        acc = ($signed(GRAD_BITS'(top)) - $signed(GRAD_BITS'(win_reg[0][0])))
              + (($signed(GRAD_BITS'(mid)) - $signed(GRAD_BITS'(win_reg[1][0]))) <<< 1)
              + ($signed(GRAD_BITS'(op.pixel)) - $signed(GRAD_BITS'(win_reg[2][0])));
        if (op.grad_zero || acc < 0)
        begin
            grad = '0;
        end
        else if (acc > $signed(GRAD_BITS'(PIX_MAX)))
        begin
            grad = PIX_MAX;
        end
        else
        begin
            grad = acc[PIXEL_BITS-1:0];
        end
    end

    always_comb
    begin
        grad_res = '0;
        grad_res.gradient_value = grad;
        end_res = '0;
        end_res.row_end = 1'b1;
        end_res.image_end = op.flush && op.last;
        push = '0;
        push.res0 = end_res;
        push.res1 = end_res;
        if (op.valid && op.flush)
        begin
            push.push0 = 1'b1;
            push.res0.row_end = op.last;
        end
        else if (op.valid && op.emit_grad)
        begin
            push.push0 = 1'b1;
            push.res0 = grad_res;
            push.push1 = op.emit_row_end;
        end
        else if (op.valid && op.emit_row_end)
        begin
            push.push0 = 1'b1;
        end
    end

    always_comb
    begin
        win_next = win_reg;
        if (op.valid && op.last)
        begin
            win_next = '0;
        end
        else if (op.valid && !op.flush)
        begin
            win_next[0][0] = win_reg[0][1];
            win_next[1][0] = win_reg[1][1];
            win_next[2][0] = win_reg[2][1];
            win_next[0][1] = top;
            win_next[1][1] = mid;
            win_next[2][1] = op.pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

endmodule

FILE: rtl/sxlf_out_fifo.sv
module sxlf_out_fifo
    import sxlf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sxlf_push_t               push,
    output logic [FIFO_CNT_BITS-1:0] count,
    output logic                     out_valid,
    input  logic                     out_ready,
    output sxlf_res_t                out_data
);

    sxlf_res_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic [1:0]               n_push;
    logic                     pop;

    always_comb
    begin
        pop = (count_reg != '0) && out_ready;
        n_push = {1'b0, push.push0} + {1'b0, push.push1};
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(n_push);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
        count_next = count_reg + FIFO_CNT_BITS'(n_push) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.push1)
        begin
            mem_reg[wr_ptr_reg + FIFO_PTR_BITS'(1)] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    assign count = count_reg;
    assign out_valid = count_reg != '0;
    assign out_data = mem_reg[rd_ptr_reg];

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.push1 |-> push.push0)
        else $error("second result pushed without the first");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.push0 |-> ({1'b0, count_reg} + {3'b000, n_push}) <= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_ptr_distance: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_PTR_BITS-1:0])
        else $error("queue pointers disagree with fill count");

endmodule

FILE: rtl/sobel_x_line_filter.sv
// Channel  Signals                          Direction  Accepted when
// in       in_valid, in_ready, in_data      into block in_valid && in_ready
// out      out_valid, out_ready, out_data   from block out_valid && out_ready
// cfg      cfg_write, cfg_index, cfg_data   into block cfg_write
//
// One request per cycle enters while in_ready is high; its results queue the cycle after.
// The line store read is registered, so the gradient is formed in the cycle after acceptance.
// Row ends past row 0 give two results; the 8-entry queue drains one per cycle on out_ready.
// in_ready drops while the queue could not absorb two more requests of two results each.
// Reset is asynchronous and active low; line stores are not cleared and need no sweep.
module sobel_x_line_filter
    import sxlf_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  sxlf_in_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output sxlf_res_t                 out_data,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int COL_BITS = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_BITS = ((COL_BITS > CFG_WIDTH_BITS) ? COL_BITS : CFG_WIDTH_BITS) + 1;

    logic [CFG_WIDTH_BITS-1:0]  width_reg;
    logic [CFG_HEIGHT_BITS-1:0] height_reg;
    logic [CMP_BITS-1:0]        width_ext;
    logic [CMP_BITS-1:0]        last_ext;
    logic [COL_BITS-1:0]        last_col;
    logic [CFG_HEIGHT_BITS-1:0] used_height;
    logic                       fire;
    logic                       rd_en;
    logic [COL_BITS-1:0]        rd_addr;
    sxlf_op_t                   op;
    logic [COL_BITS-1:0]        op_addr;
    logic [PIXEL_BITS-1:0]      top;
    logic [PIXEL_BITS-1:0]      mid;
    logic                       st_wr;
    sxlf_push_t                 push;
    logic [FIFO_CNT_BITS-1:0]   q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_data[CFG_WIDTH_BITS-1:0];
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_reg <= cfg_data[CFG_HEIGHT_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        width_ext = CMP_BITS'(width_reg);
        if (width_ext < CMP_BITS'(3))
        begin
            last_ext = CMP_BITS'(2);
        end
        else if (width_ext > CMP_BITS'(MAX_WIDTH))
        begin
            last_ext = CMP_BITS'(MAX_WIDTH - 1);
        end
        else
        begin
            last_ext = width_ext - CMP_BITS'(1);
        end
        last_col = last_ext[COL_BITS-1:0];
        used_height = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
    end

    assign in_ready = 32'(q_count) + 2 * PUSH_MAX <= FIFO_DEPTH;
    assign fire = in_valid && in_ready;
    assign st_wr = op.valid && !op.flush;

    sxlf_ctrl #(
        .COL_BITS (COL_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .in_data     (in_data),
        .last_col    (last_col),
        .used_height (used_height),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .op          (op),
        .op_addr     (op_addr)
    );

    sxlf_line_store #(
        .DEPTH     (MAX_WIDTH),
        .ADDR_BITS (COL_BITS)
    ) u_older (
        .clk     (clk),
        .wr_en   (st_wr),
        .wr_addr (op_addr),
        .wr_data (mid),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (top)
    );

    sxlf_line_store #(
        .DEPTH     (MAX_WIDTH),
        .ADDR_BITS (COL_BITS)
    ) u_newer (
        .clk     (clk),
        .wr_en   (st_wr),
        .wr_addr (op_addr),
        .wr_data (op.pixel),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (mid)
    );

    sxlf_grad u_grad (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .top   (top),
        .mid   (mid),
        .push  (push)
    );

    sxlf_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .count     (q_count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
